// File: hdl/ordered_spill_fifo_with_bypass_core_defines.svh
// Assertion macros for the spill FIFO core.
// Used by the top level only; needs aclk and aresetn in scope.
`ifndef ORDERED_SPILL_FIFO_WITH_BYPASS_CORE_DEFINES_SVH
`define ORDERED_SPILL_FIFO_WITH_BYPASS_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define OSFB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset
`define OSFB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/osfb_pkg.sv
// Shared constants, types and the front-to-back command for the spill FIFO core.
// No dependencies.
`timescale 1ns / 1ps

package osfb_pkg;

    localparam int SPILL_PACKETS  = 2048;
    localparam int WINDOW_PACKETS = 64;
    localparam int CMD_DEPTH      = 4;

    localparam int WORD_W  = 32;
    localparam int SLOT_W  = 6;
    localparam int STAT_W  = 12;
    localparam int PTR_W   = (SPILL_PACKETS > 1) ? $clog2(SPILL_PACKETS) : 1;
    localparam int OCC_W   = $clog2(SPILL_PACKETS + 1);
    localparam int FILL_W  = $clog2(WINDOW_PACKETS + 1);
    localparam int CMP_W   = (OCC_W > FILL_W) ? OCC_W : FILL_W;
    localparam int CQ_PTR_W = $clog2(CMD_DEPTH);
    localparam int CQ_CNT_W = $clog2(CMD_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_SEND  = 2'd0,
        MODE_DRAIN = 2'd1,
        MODE_TAKEN = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CMD_STATUS = 2'd0,  // status beat only
        CMD_BYPASS = 2'd1,  // packet straight into the window
        CMD_SPILL  = 2'd2,  // packet into the spill store
        CMD_DRAIN  = 2'd3   // count packets from store into window
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [WORD_W-1:0]  packet;
        logic [PTR_W-1:0]   addr;
        logic [SLOT_W-1:0]  slot;
        logic [FILL_W-1:0]  count;
        logic               accepted;
        logic [STAT_W-1:0]  pending;
        logic [STAT_W-1:0]  peak;
        logic [WORD_W-1:0]  drops;
    } cmd_t;

endpackage

// File: hdl/osfb_front.sv
// Front end: accepts input beats, keeps FIFO/window bookkeeping, issues commands.
// Depends on osfb_pkg.
`timescale 1ns / 1ps

module osfb_front import osfb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    input  logic [WORD_W-1:0] s_packet,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output cmd_t              cmd
);

    logic [PTR_W-1:0]  rd_ptr_reg,  rd_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_reg,  wr_ptr_next;
    logic [OCC_W-1:0]  occ_reg,     occ_next;
    logic [OCC_W-1:0]  peak_reg,    peak_next;
    logic [WORD_W-1:0] drops_reg,   drops_next;
    logic [FILL_W-1:0] fill_reg,    fill_next;

    logic [FILL_W-1:0] avail;
    logic [FILL_W-1:0] n_move;
    logic [PTR_W:0]    rd_sum;
    logic              push;

    assign s_ready   = cmd_ready;
    assign cmd_valid = s_valid;
    assign push      = s_valid && cmd_ready;

    assign avail  = FILL_W'(WINDOW_PACKETS) - fill_reg;
    assign n_move = (CMP_W'(occ_reg) < CMP_W'(avail)) ? FILL_W'(occ_reg) : avail;
    // n_move never exceeds occupancy, so one wrap corrects the sum
    assign rd_sum = {1'b0, rd_ptr_reg} + (PTR_W+1)'(n_move);

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        occ_next    = occ_reg;
        peak_next   = peak_reg;
        drops_next  = drops_reg;
        fill_next   = fill_reg;

        cmd.kind     = CMD_STATUS;
        cmd.packet   = s_packet;
        cmd.addr     = wr_ptr_reg;
        cmd.slot     = SLOT_W'(fill_reg);
        cmd.count    = n_move;
        cmd.accepted = 1'b0;

        unique case (mode_t'(s_mode))
            MODE_SEND: begin
                if (occ_reg == '0 && fill_reg < FILL_W'(WINDOW_PACKETS)) begin
                    cmd.kind     = CMD_BYPASS;
                    cmd.accepted = 1'b1;
                    fill_next    = fill_reg + 1'b1;
                end else if (occ_reg < OCC_W'(SPILL_PACKETS)) begin
                    cmd.kind     = CMD_SPILL;
                    cmd.accepted = 1'b1;
                    wr_ptr_next  = (wr_ptr_reg == PTR_W'(SPILL_PACKETS - 1)) ?
                                   '0 : wr_ptr_reg + 1'b1;
                    occ_next     = occ_reg + 1'b1;
                    if (occ_next > peak_reg) begin
                        peak_next = occ_next;
                    end
                end else if (drops_reg != '1) begin
                    drops_next = drops_reg + 1'b1;
                end
            end
            MODE_DRAIN: begin
                if (n_move != '0) begin
                    cmd.kind    = CMD_DRAIN;
                    cmd.addr    = rd_ptr_reg;
                    rd_ptr_next = (rd_sum >= (PTR_W+1)'(SPILL_PACKETS)) ?
                                  PTR_W'(rd_sum - (PTR_W+1)'(SPILL_PACKETS)) :
                                  PTR_W'(rd_sum);
                    occ_next    = occ_reg - OCC_W'(n_move);
                    fill_next   = fill_reg + n_move;
                end
            end
            MODE_TAKEN: begin
                fill_next = '0;
            end
            MODE_CLEAR: begin
                rd_ptr_next = '0;
                wr_ptr_next = '0;
                occ_next    = '0;
                peak_next   = '0;
                drops_next  = '0;
            end
        endcase

        // stats travel with the command as they stand after the whole item
        cmd.pending = STAT_W'(occ_next);
        cmd.peak    = STAT_W'(peak_next);
        cmd.drops   = drops_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            occ_reg    <= '0;
            peak_reg   <= '0;
            drops_reg  <= '0;
            fill_reg   <= '0;
        end else if (push) begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            occ_reg    <= occ_next;
            peak_reg   <= peak_next;
            drops_reg  <= drops_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// File: hdl/osfb_cmd_queue.sv
// Short command queue between front and back ends.
// Depends on osfb_pkg.
`timescale 1ns / 1ps

module osfb_cmd_queue import osfb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    cmd_t                entry_reg [CMD_DEPTH];
    logic [CQ_PTR_W-1:0] wr_reg, rd_reg;
    logic [CQ_CNT_W-1:0] cnt_reg;
    logic                push, pop;

    assign in_ready  = cnt_reg != CQ_CNT_W'(CMD_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_cmd   = entry_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == CQ_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == CQ_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// File: hdl/osfb_back.sv
// Back end: owns the spill store, executes commands and drives the result beats.
// Depends on osfb_pkg.
`timescale 1ns / 1ps

module osfb_back import osfb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_write_valid,
    output logic [SLOT_W-1:0] m_window_slot,
    output logic [WORD_W-1:0] m_window_packet,
    output logic              m_accepted,
    output logic [STAT_W-1:0] m_pending_packets,
    output logic [STAT_W-1:0] m_peak_packets,
    output logic [WORD_W-1:0] m_drop_count,
    output logic              m_last
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;

    logic [WORD_W-1:0] spill_mem [SPILL_PACKETS];
    logic [WORD_W-1:0] rd_data_reg;

    cmd_t              cur_reg;
    logic [PTR_W-1:0]  addr_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [FILL_W-1:0] left_reg;

    logic pop, is_drain, more;

    assign cmd_ready = state_reg == S_IDLE;
    assign pop       = cmd_valid && cmd_ready;
    assign is_drain  = cur_reg.kind == CMD_DRAIN;
    assign more      = is_drain && left_reg != FILL_W'(1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (pop) begin
                    state_next = (cmd.kind == CMD_DRAIN) ? S_READ : S_OUT;
                end
            end
            S_READ: state_next = S_OUT;
            S_OUT: begin
                if (m_ready) begin
                    state_next = more ? S_READ : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // spill store: one write port from spill commands, one registered read port
    always_ff @(posedge aclk) begin
        if (pop && cmd.kind == CMD_SPILL) begin
            spill_mem[cmd.addr] <= cmd.packet;
        end
        if (state_reg == S_READ) begin
            rd_data_reg <= spill_mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            addr_reg  <= '0;
            slot_reg  <= '0;
            left_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (pop) begin
                addr_reg <= cmd.addr;
                slot_reg <= cmd.slot;
                left_reg <= cmd.count;
            end else if (state_reg == S_OUT && m_ready && more) begin
                addr_reg <= (addr_reg == PTR_W'(SPILL_PACKETS - 1)) ? '0 : addr_reg + 1'b1;
                slot_reg <= slot_reg + 1'b1;
                left_reg <= left_reg - 1'b1;
            end
        end
    end

    assign m_valid           = state_reg == S_OUT;
    assign m_write_valid     = is_drain || cur_reg.kind == CMD_BYPASS;
    assign m_window_slot     = m_write_valid ? slot_reg : '0;
    assign m_window_packet   = is_drain ? rd_data_reg :
                               (cur_reg.kind == CMD_BYPASS) ? cur_reg.packet : '0;
    assign m_accepted        = cur_reg.accepted;
    assign m_pending_packets = cur_reg.pending;
    assign m_peak_packets    = cur_reg.peak;
    assign m_drop_count      = cur_reg.drops;
    assign m_last            = !more;

endmodule

// File: hdl/ordered_spill_fifo_with_bypass_core.sv
// Channel | direction | fields
// s_      | in        | mode, packet
// m_      | out       | write_valid, window_slot, window_packet, accepted,
//         |           | pending_packets, peak_packets, drop_count, last
//
// Front end takes a beat per cycle while the command queue has room.
// Back end: a status/send result takes a command pop, then the result beat;
// a drain takes a pop, then per moved packet a read of the spill store and
// the result beat, and moves up to 64 packets.
// aresetn is synchronous; the spill store is not cleared (never read unwritten).
// Either side may stall; the command queue decouples them.
// Top level of the spill FIFO core; depends on osfb_pkg, osfb_front,
// osfb_cmd_queue, osfb_back and the defines header.
`timescale 1ns / 1ps
`include "ordered_spill_fifo_with_bypass_core_defines.svh"

module ordered_spill_fifo_with_bypass_core import osfb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    input  logic [WORD_W-1:0] s_packet,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_write_valid,
    output logic [SLOT_W-1:0] m_window_slot,
    output logic [WORD_W-1:0] m_window_packet,
    output logic              m_accepted,
    output logic [STAT_W-1:0] m_pending_packets,
    output logic [STAT_W-1:0] m_peak_packets,
    output logic [WORD_W-1:0] m_drop_count,
    output logic              m_last
);

    logic f_valid, f_ready, b_valid, b_ready;
    cmd_t f_cmd, b_cmd;

    osfb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_packet  (s_packet),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    osfb_cmd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_cmd   (b_cmd)
    );

    osfb_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd_valid         (b_valid),
        .cmd_ready         (b_ready),
        .cmd               (b_cmd),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_write_valid     (m_write_valid),
        .m_window_slot     (m_window_slot),
        .m_window_packet   (m_window_packet),
        .m_accepted        (m_accepted),
        .m_pending_packets (m_pending_packets),
        .m_peak_packets    (m_peak_packets),
        .m_drop_count      (m_drop_count),
        .m_last            (m_last)
    );

    `OSFB_ASSERT_NOW(a_peak_covers_pending, m_valid,
        m_pending_packets <= m_peak_packets, "pending above peak")

    `OSFB_ASSERT_NOW(a_multi_only_drain, m_valid && !m_last,
        m_write_valid && !m_accepted, "non-final beat that is not a drained packet")

    `OSFB_ASSERT_NOW(a_status_zeroed, m_valid && !m_write_valid,
        m_window_slot == '0 && m_window_packet == '0, "status beat carries data")

    `OSFB_ASSERT_NEXT(a_drain_slot_steps, m_valid && m_ready && !m_last,
        m_window_slot == $past(m_window_slot) + 1'b1, "drain slot did not advance")

endmodule

// File: dv/ordered_spill_fifo_with_bypass_core_test.sv
// Self-checking bench for the spill FIFO core: directed and random packet traffic,
// every result beat compared against an in-bench prediction of window writes and stats.
// Depends on osfb_pkg and ordered_spill_fifo_with_bypass_core.
`timescale 1ns / 1ps

module ordered_spill_fifo_with_bypass_core_test;
    import osfb_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_ITEMS = 130;
    localparam int CALM_ITEMS   = 30;
    localparam int BACKLOG      = 72;
    localparam int SETTLE       = 24;

    typedef struct packed {
        logic              write_valid;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] packet;
        logic              accepted;
        logic [STAT_W-1:0] pending;
        logic [STAT_W-1:0] peak;
        logic [WORD_W-1:0] drops;
        logic              last;
    } window_beat_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [1:0]        s_mode = MODE_TAKEN;
    logic [WORD_W-1:0] s_packet = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_write_valid;
    logic [SLOT_W-1:0] m_window_slot;
    logic [WORD_W-1:0] m_window_packet;
    logic              m_accepted;
    logic [STAT_W-1:0] m_pending_packets;
    logic [STAT_W-1:0] m_peak_packets;
    logic [WORD_W-1:0] m_drop_count;
    logic              m_last;

    // Predicted spill FIFO and window state
    logic [WORD_W-1:0] spill_mem [SPILL_PACKETS];
    logic [PTR_W-1:0]  rd_ptr = '0;
    logic [PTR_W-1:0]  wr_ptr = '0;
    int                spill_occ = 0;
    int                spill_peak = 0;
    logic [WORD_W-1:0] drop_total = '0;
    int                window_fill = 0;

    window_beat_t beats_due[$];
    int           mismatches = 0;
    bit           calm = 1'b0;

    ordered_spill_fifo_with_bypass_core uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_packet          (s_packet),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_write_valid     (m_write_valid),
        .m_window_slot     (m_window_slot),
        .m_window_packet   (m_window_packet),
        .m_accepted        (m_accepted),
        .m_pending_packets (m_pending_packets),
        .m_peak_packets    (m_peak_packets),
        .m_drop_count      (m_drop_count),
        .m_last            (m_last)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Works out the result beats of one accepted item and queues them
    function automatic void model_spill_step(input mode_t md, input logic [WORD_W-1:0] pkt);
        window_beat_t step_q[$];
        window_beat_t b;
        b = '0;
        case (md)
            MODE_SEND: begin
                if (spill_occ == 0 && window_fill < WINDOW_PACKETS) begin
                    b.write_valid = 1'b1;
                    b.slot        = SLOT_W'(window_fill);
                    b.packet      = pkt;
                    b.accepted    = 1'b1;
                    window_fill++;
                end else if (spill_occ < SPILL_PACKETS) begin
                    spill_mem[wr_ptr] = pkt;
                    wr_ptr = (wr_ptr == PTR_W'(SPILL_PACKETS - 1)) ? '0 : wr_ptr + 1'b1;
                    spill_occ++;
                    if (spill_occ > spill_peak) spill_peak = spill_occ;
                    b.accepted = 1'b1;
                end else if (drop_total != '1) begin
                    drop_total++;
                end
                step_q.push_back(b);
            end
            MODE_DRAIN: begin
                while (spill_occ > 0 && window_fill < WINDOW_PACKETS) begin
                    b             = '0;
                    b.write_valid = 1'b1;
                    b.slot        = SLOT_W'(window_fill);
                    b.packet      = spill_mem[rd_ptr];
                    rd_ptr = (rd_ptr == PTR_W'(SPILL_PACKETS - 1)) ? '0 : rd_ptr + 1'b1;
                    spill_occ--;
                    window_fill++;
                    step_q.push_back(b);
                end
                if (step_q.size() == 0) step_q.push_back('0);
            end
            MODE_TAKEN: begin
                window_fill = 0;
                step_q.push_back(b);
            end
            default: begin
                rd_ptr     = '0;
                wr_ptr     = '0;
                spill_occ  = 0;
                spill_peak = 0;
                drop_total = '0;
                step_q.push_back(b);
            end
        endcase
        foreach (step_q[k]) begin
            step_q[k].pending = STAT_W'(spill_occ);
            step_q[k].peak    = STAT_W'(spill_peak);
            step_q[k].drops   = drop_total;
            step_q[k].last    = (k == step_q.size() - 1);
            beats_due.push_back(step_q[k]);
        end
    endfunction

    function automatic void check_field(input string field, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endfunction

    // Prediction first, then comparison, so a same-edge beat never races its item
    always @(posedge aclk) begin : monitor
        window_beat_t want;
        if (aresetn) begin
            if (s_valid && s_ready) model_spill_step(mode_t'(s_mode), s_packet);
            if (m_valid && m_ready) begin
                if (beats_due.size() == 0) begin
                    $error("result beat with nothing outstanding");
                    mismatches++;
                end else begin
                    want = beats_due.pop_front();
                    check_field("write_valid", want.write_valid, m_write_valid);
                    check_field("window_slot", want.slot, m_window_slot);
                    check_field("window_packet", want.packet, m_window_packet);
                    check_field("accepted", want.accepted, m_accepted);
                    check_field("pending_packets", want.pending, m_pending_packets);
                    check_field("peak_packets", want.peak, m_peak_packets);
                    check_field("drop_count", want.drops, m_drop_count);
                    check_field("last", want.last, m_last);
                end
            end
        end
    end

    // Receiver back-pressure in short bursts
    initial begin : sink_stalls
        int hold;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 4);
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("ordered_spill_fifo_with_bypass_core verification failed");
        $finish;
    end

    // Leaves valid high on return; whoever idles next lowers it
    task automatic send_beat(input mode_t md, input logic [WORD_W-1:0] pkt);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_mode   <= md;
        s_packet <= pkt;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (beats_due.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [WORD_W-1:0] pick_packet();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic fill_window();
        repeat (WINDOW_PACKETS) send_beat(MODE_SEND, pick_packet());
    endtask

    task automatic test_bypass_extremes();
        send_beat(MODE_TAKEN, '1);
        send_beat(MODE_DRAIN, '1);              // nothing queued: status only
        send_beat(MODE_SEND, 32'h0000_0000);
        send_beat(MODE_SEND, 32'hFFFF_FFFF);
        send_beat(MODE_SEND, 32'h5555_5555);
        send_beat(MODE_SEND, 32'hAAAA_AAAA);
        send_beat(MODE_SEND, 32'h8000_0001);
        send_beat(MODE_CLEAR, 32'h1234_5678);   // window fill survives a clear
        send_beat(MODE_SEND, 32'h0102_0304);
        send_beat(MODE_TAKEN, '0);
        send_beat(MODE_SEND, 32'hDEAD_BEEF);
        hold_until_drained();
    endtask

    task automatic test_queue_before_window();
        send_beat(MODE_TAKEN, '0);
        fill_window();
        repeat (3) send_beat(MODE_SEND, $urandom);
        send_beat(MODE_CLEAR, '0);              // pointers back to zero, window still full
        send_beat(MODE_SEND, 32'hC0FF_EE01);
        send_beat(MODE_DRAIN, '0);              // window full: status only
        send_beat(MODE_TAKEN, '0);
        send_beat(MODE_SEND, 32'hC0FF_EE02);    // must queue behind the backlog
        send_beat(MODE_DRAIN, '0);
        hold_until_drained();
    endtask

    // Backlog longer than one window, drained over several windows
    task automatic test_backlog_drains();
        send_beat(MODE_TAKEN, '0);
        fill_window();
        repeat (BACKLOG) send_beat(MODE_SEND, pick_packet());
        send_beat(MODE_DRAIN, '0);              // window full: status only
        hold_until_drained();
        repeat (2) begin
            send_beat(MODE_TAKEN, $urandom);
            send_beat(MODE_DRAIN, $urandom);
        end
        send_beat(MODE_TAKEN, '0);
        send_beat(MODE_DRAIN, '0);              // FIFO empty: status only
        send_beat(MODE_CLEAR, '0);              // peak back to zero
        hold_until_drained();
    endtask

    task automatic test_random_traffic();
        int sent;
        int burst;
        int roll;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                hold_until_drained();
                paused = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                burst = (roll < 8) ? $urandom_range(30, 80) : $urandom_range(1, 16);
                repeat (burst) send_beat(MODE_SEND, pick_packet());
                sent += burst;
            end else begin
                if (roll < 77)      send_beat(MODE_DRAIN, $urandom);
                else if (roll < 97) send_beat(MODE_TAKEN, $urandom);
                else                send_beat(MODE_CLEAR, $urandom);
                sent++;
            end
        end
        hold_until_drained();
    endtask

    initial begin : run
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_bypass_extremes();
        test_queue_before_window();
        test_backlog_drains();
        test_random_traffic();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && beats_due.size() == 0) begin
            $display("ordered_spill_fifo_with_bypass_core verification clean");
        end else begin
            $display("ordered_spill_fifo_with_bypass_core verification failed");
        end
        $finish;
    end

endmodule
